[src/gdfw_pkg.sv]
// Shared constants and result codes for the depth-first graph walker.
package gdfw_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam int VERTEX_W = 6;
    localparam int VCOUNT_W = 7;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic [1:0] ST_VISIT  = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_WALK = 1'b1;

endpackage

[src/gdfw_ram.sv]
// Generic single-write, single-read memory with a registered read port.
module gdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/graph_depth_first_walk.sv]
// Top level of the depth-first graph walker with adjacency-list edge storage.
//
//   Channel  Signals                                     Direction
//   input    in_valid, in_ready, func, first_vertex,     into block
//            second_vertex
//   output   out_valid, out_ready, visited_vertex,       out of block
//            status, last
//   config   cfg_we, cfg_data                            into block
//
// A stored edge word passes through the edge write and response states, a refused
// word through the response state alone, before ready returns. A walk is paced
// by the single read port of the edge, list head and stack memories.
// Reset clears the list heads, visited marks and edge count at once; the
// memories themselves need no clearing. Output stalls hold the walk in place.
module graph_depth_first_walk #(
    parameter int MAX_VERTICES = gdfw_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = gdfw_pkg::MAX_EDGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [gdfw_pkg::VERTEX_W-1:0]     first_vertex,
    input  logic [gdfw_pkg::VERTEX_W-1:0]     second_vertex,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gdfw_pkg::VERTEX_W-1:0]     visited_vertex,
    output logic [1:0]                        status,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [gdfw_pkg::VCOUNT_W-1:0]     cfg_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int DW  = $clog2(MAX_VERTICES + 1);
    localparam int PW  = gdfw_pkg::VERTEX_W;
    localparam int XW  = (VW > PW) ? VW : PW;
    localparam int LW  = (DW > gdfw_pkg::VCOUNT_W) ? DW : gdfw_pkg::VCOUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_EWR,
        S_HEAD,
        S_STEP,
        S_POP,
        S_EDGE,
        S_VISIT,
        S_FINISH
    } state_t;

    function automatic logic [VW-1:0] to_vid(input logic [PW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[VW-1:0];
    endfunction

    function automatic logic [PW-1:0] to_port(input logic [VW-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[PW-1:0];
    endfunction

    state_t                         state_reg;
    logic [gdfw_pkg::VCOUNT_W-1:0]  vcount_reg;
    logic [CW-1:0]                  edges_stored_reg;
    logic                           head_valid_reg [MAX_VERTICES];
    logic                           seen_reg [MAX_VERTICES];
    logic [DW-1:0]                  depth_reg;
    logic [VW-1:0]                  tgt_reg;
    logic [VW-1:0]                  b_reg;
    logic [VW-1:0]                  pending_reg;
    logic [VW-1:0]                  top_vertex_reg;
    logic [CW-1:0]                  top_code_reg;
    logic [1:0]                     status_reg;
    logic                           out_valid_reg;
    logic [PW-1:0]                  out_vertex_reg;
    logic [1:0]                     out_status_reg;
    logic                           out_last_reg;

    logic             out_free;
    logic [LW-1:0]    lim;
    logic [LW-1:0]    vc_ext;
    logic [LW-1:0]    max_ext;
    logic             a_bad;
    logic             b_bad;
    logic             store_full;
    logic [VW-1:0]    a_idx;
    logic [CW-1:0]    head_code;
    logic [CW-1:0]    top_code_m1;
    logic [DW-1:0]    depth_m1;
    logic [DW-1:0]    depth_m2;

    logic             head_we;
    logic [VW-1:0]    head_raddr;
    logic [CW-1:0]    head_rdata;
    logic             edge_we;
    logic [VW+CW-1:0] edge_rdata;
    logic [VW-1:0]    edge_tgt;
    logic [CW-1:0]    edge_link;
    logic             stack_we;
    logic [VW+CW-1:0] stack_rdata;

    assign out_free    = !out_valid_reg || out_ready;
    assign vc_ext      = LW'(vcount_reg);
    assign max_ext     = LW'(MAX_VERTICES);
    assign lim         = (vc_ext > max_ext) ? max_ext : vc_ext;
    assign a_bad       = LW'(first_vertex) >= lim;
    assign b_bad       = LW'(second_vertex) >= lim;
    assign store_full  = edges_stored_reg >= CW'(MAX_EDGES);
    assign a_idx       = to_vid(first_vertex);
    assign head_code   = head_valid_reg[tgt_reg] ? head_rdata : '0;
    assign top_code_m1 = top_code_reg - CW'(1);
    assign depth_m1    = depth_reg - DW'(1);
    assign depth_m2    = depth_reg - DW'(2);
    assign edge_tgt    = edge_rdata[VW+CW-1:CW];
    assign edge_link   = edge_rdata[CW-1:0];

    assign head_we    = (state_reg == S_EWR);
    assign head_raddr = (state_reg == S_IDLE) ? a_idx : tgt_reg;
    assign edge_we    = (state_reg == S_EWR);
    assign stack_we   = (state_reg == S_VISIT) && out_free;

    gdfw_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_VERTICES)
    ) u_head_ram (
        .clk  (clk),
        .we   (head_we),
        .waddr(tgt_reg),
        .wdata(edges_stored_reg + CW'(1)),
        .raddr(head_raddr),
        .rdata(head_rdata)
    );

    gdfw_ram #(
        .WIDTH(VW + CW),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .clk  (clk),
        .we   (edge_we),
        .waddr(edges_stored_reg[EAW-1:0]),
        .wdata({b_reg, head_code}),
        .raddr(top_code_m1[EAW-1:0]),
        .rdata(edge_rdata)
    );

    gdfw_ram #(
        .WIDTH(VW + CW),
        .DEPTH(MAX_VERTICES)
    ) u_stack_ram (
        .clk  (clk),
        .we   (stack_we),
        .waddr(depth_m1[VW-1:0]),
        .wdata({top_vertex_reg, top_code_reg}),
        .raddr(depth_m2[VW-1:0]),
        .rdata(stack_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vcount_reg       <= gdfw_pkg::VCOUNT_RESET;
            edges_stored_reg <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                head_valid_reg[i] <= 1'b0;
                seen_reg[i]       <= 1'b0;
            end
            depth_reg      <= '0;
            tgt_reg        <= '0;
            b_reg          <= '0;
            pending_reg    <= '0;
            top_vertex_reg <= '0;
            top_code_reg   <= '0;
            status_reg     <= gdfw_pkg::ST_VISIT;
            out_valid_reg  <= 1'b0;
            out_vertex_reg <= '0;
            out_status_reg <= gdfw_pkg::ST_VISIT;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        tgt_reg <= a_idx;
                        b_reg   <= to_vid(second_vertex);
                        if (func == gdfw_pkg::FUNC_EDGE)
                        begin
                            if (a_bad || b_bad)
                            begin
                                status_reg <= gdfw_pkg::ST_RANGE;
                                state_reg  <= S_RESP;
                            end
                            else if (store_full)
                            begin
                                status_reg <= gdfw_pkg::ST_FULL;
                                state_reg  <= S_RESP;
                            end
                            else
                            begin
                                state_reg <= S_EWR;
                            end
                        end
                        else if (a_bad)
                        begin
                            status_reg <= gdfw_pkg::ST_RANGE;
                            state_reg  <= S_RESP;
                        end
                        else
                        begin
                            seen_reg[a_idx] <= 1'b1;
                            pending_reg     <= a_idx;
                            top_vertex_reg  <= a_idx;
                            depth_reg       <= '0;
                            state_reg       <= S_HEAD;
                        end
                    end
                end
                S_EWR:
                begin
                    edges_stored_reg        <= edges_stored_reg + CW'(1);
                    head_valid_reg[tgt_reg] <= 1'b1;
                    status_reg              <= gdfw_pkg::ST_STORED;
                    state_reg               <= S_RESP;
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_vertex_reg <= '0;
                        out_status_reg <= status_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_HEAD:
                begin
                    top_code_reg <= head_code;
                    depth_reg    <= depth_reg + DW'(1);
                    state_reg    <= S_STEP;
                end
                S_STEP:
                begin
                    if (top_code_reg == '0)
                    begin
                        if (depth_reg == DW'(1))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_POP:
                begin
                    top_vertex_reg <= stack_rdata[VW+CW-1:CW];
                    top_code_reg   <= stack_rdata[CW-1:0];
                    depth_reg      <= depth_m1;
                    state_reg      <= S_STEP;
                end
                S_EDGE:
                begin
                    top_code_reg <= edge_link;
                    tgt_reg      <= edge_tgt;
                    if (seen_reg[edge_tgt])
                    begin
                        state_reg <= S_STEP;
                    end
                    else
                    begin
                        state_reg <= S_VISIT;
                    end
                end
                S_VISIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_vertex_reg    <= to_port(pending_reg);
                        out_status_reg    <= gdfw_pkg::ST_VISIT;
                        out_last_reg      <= 1'b0;
                        pending_reg       <= tgt_reg;
                        seen_reg[tgt_reg] <= 1'b1;
                        top_vertex_reg    <= tgt_reg;
                        state_reg         <= S_HEAD;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_vertex_reg <= to_port(pending_reg);
                        out_status_reg <= gdfw_pkg::ST_VISIT;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign visited_vertex = out_vertex_reg;
    assign status         = out_status_reg;
    assign last           = out_last_reg;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the depth-first graph walker with adjacency-list edge storage.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       op;
        logic [5:0] from_v;
        logic [5:0] to_v;
        bit         hold;
    } graph_word_t;

    typedef struct {
        logic [5:0] vertex;
        logic [1:0] code;
        logic       last;
    } visit_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       func = gdfw_pkg::FUNC_EDGE;
    logic [5:0] first_vertex = '0;
    logic [5:0] second_vertex = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [5:0] visited_vertex;
    logic [1:0] status;
    logic       last;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_data = gdfw_pkg::VCOUNT_RESET;

    graph_word_t pending_words[$];
    graph_word_t live_word;
    visit_t      due_visits[$];

    logic [6:0] vcount_model = gdfw_pkg::VCOUNT_RESET;
    logic [8:0] list_first[0:gdfw_pkg::MAX_VERTICES_DEF-1];
    logic [5:0] edge_dst[0:gdfw_pkg::MAX_EDGES_DEF-1];
    logic [8:0] edge_next[0:gdfw_pkg::MAX_EDGES_DEF-1];
    logic [8:0] st_code[0:gdfw_pkg::MAX_VERTICES_DEF-1];
    bit         seen[0:gdfw_pkg::MAX_VERTICES_DEF-1];
    int         edges_held = 0;

    bit steady = 1'b0;
    int words_queued = 0;
    int words_taken = 0;
    int planned_edges = 0;
    int mismatches = 0;
    int settings_used = 0;
    int edges_refused_full = 0;
    int range_refusals = 0;
    int walks_run = 0;
    int visits_checked = 0;
    int longest_walk = 0;

    graph_depth_first_walk dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .first_vertex   (first_vertex),
        .second_vertex  (second_vertex),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visited_vertex (visited_vertex),
        .status         (status),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [6:0] usable_count();
        return (vcount_model > 7'd64) ? 7'd64 : vcount_model;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic add_due(input logic [5:0] vertex, input logic [1:0] code, input logic fin);
        visit_t v;
        v.vertex = vertex;
        v.code = code;
        v.last = fin;
        due_visits.push_back(v);
    endtask

    task automatic walk_or_store(input graph_word_t w);
        logic [6:0] lim;
        logic [5:0] order[$];
        logic [5:0] t;
        logic [8:0] code;
        int depth;
        lim = usable_count();
        if (w.op == gdfw_pkg::FUNC_EDGE) begin
            if (w.from_v >= lim || w.to_v >= lim) begin
                add_due(6'd0, gdfw_pkg::ST_RANGE, 1'b1);
                range_refusals++;
            end
            else if (edges_held >= gdfw_pkg::MAX_EDGES_DEF) begin
                add_due(6'd0, gdfw_pkg::ST_FULL, 1'b1);
                edges_refused_full++;
            end
            else begin
                edge_dst[edges_held] = w.to_v;
                edge_next[edges_held] = list_first[w.from_v];
                list_first[w.from_v] = 9'(edges_held + 1);
                edges_held++;
                add_due(6'd0, gdfw_pkg::ST_STORED, 1'b1);
            end
        end
        else if (w.from_v >= lim) begin
            add_due(6'd0, gdfw_pkg::ST_RANGE, 1'b1);
            range_refusals++;
        end
        else begin
            walks_run++;
            seen[w.from_v] = 1'b1;
            order.push_back(w.from_v);
            st_code[0] = list_first[w.from_v];
            depth = 1;
            while (depth > 0) begin
                code = st_code[depth-1];
                if (code == 9'd0 || code > gdfw_pkg::MAX_EDGES_DEF) begin
                    depth--;
                end
                else begin
                    st_code[depth-1] = edge_next[code-1];
                    t = edge_dst[code-1];
                    if (!seen[t] && depth < gdfw_pkg::MAX_VERTICES_DEF
                        && order.size() < gdfw_pkg::MAX_VERTICES_DEF) begin
                        seen[t] = 1'b1;
                        order.push_back(t);
                        st_code[depth] = list_first[t];
                        depth++;
                    end
                end
            end
            if (order.size() > longest_walk)
                longest_walk = order.size();
            foreach (order[i])
                add_due(order[i], gdfw_pkg::ST_VISIT, i == order.size() - 1);
        end
    endtask

    task automatic queue_word(input logic op, input logic [5:0] from_v,
                              input logic [5:0] to_v, input bit hold);
        graph_word_t w;
        w.op = op;
        w.from_v = from_v;
        w.to_v = to_v;
        w.hold = hold;
        if (op == gdfw_pkg::FUNC_EDGE && from_v < usable_count() && to_v < usable_count())
            planned_edges++;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || due_visits.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [6:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        vcount_model = v;
        settings_used++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin : drive
            bit took;
            took = in_valid && in_ready;
            if (took) begin
                walk_or_store(live_word);
                words_taken++;
            end
            if (!in_valid || took) begin
                if (pending_words.size() > 0
                    && !(pending_words[0].hold && due_visits.size() > 0)
                    && (steady || $urandom_range(0, 99) >= 10)) begin
                    live_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    func <= live_word.op;
                    first_vertex <= live_word.from_v;
                    second_vertex <= live_word.to_v;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin : watch
            visit_t want;
            if (out_valid && out_ready) begin
                if (due_visits.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: vertex %0d status %0d last %0b",
                                            visited_vertex, status, last));
                end
                else begin
                    want = due_visits.pop_front();
                    if (want.code == gdfw_pkg::ST_VISIT)
                        visits_checked++;
                    if (visited_vertex !== want.vertex)
                        flag_mismatch($sformatf("visited_vertex %0d, expected %0d",
                                                visited_vertex, want.vertex));
                    if (status !== want.code)
                        flag_mismatch($sformatf("status %0d, expected %0d (vertex %0d)",
                                                status, want.code, want.vertex));
                    if (last !== want.last)
                        flag_mismatch($sformatf("last %0b, expected %0b (vertex %0d)",
                                                last, want.last, want.vertex));
                end
            end
            out_ready <= steady || $urandom_range(0, 99) >= 10;
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int base;
        int walks;
        for (int i = 0; i < gdfw_pkg::MAX_VERTICES_DEF; i++) begin
            list_first[i] = '0;
            seen[i] = 1'b0;
            st_code[i] = '0;
        end
        for (int i = 0; i < gdfw_pkg::MAX_EDGES_DEF; i++) begin
            edge_dst[i] = '0;
            edge_next[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes of both vertex fields, then a small graph whose walk crosses vertex 40.
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd63, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd0, 6'd63, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd5, 6'd6, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd6, 6'd40, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd5, 6'd7, 1'b0);

        // Edges already stored must still be followed into vertices now refused.
        set_vertex_count(7'd10);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd5, 6'd63, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd5, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd9, 6'd10, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd10, 6'd9, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd10, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd9, 6'd9, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd9, 6'd0, 1'b0);

        set_vertex_count(7'd1);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd0, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd0, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd63, 6'd63, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd1, 6'd0, 1'b0);

        set_vertex_count(7'd0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd0, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd0, 6'd0, 1'b0);

        set_vertex_count(7'd64);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd63, 6'd0, 1'b0);

        // Each phase builds a graph over eight fresh vertices and then walks it.
        for (int p = 0; p < 7; p++) begin
            base = 8 * (p + 1);
            if (p == 0)
                set_vertex_count(7'd127);
            else if (p == 4)
                set_vertex_count(7'(base + 4));
            else
                set_vertex_count(7'($urandom_range(base + 8, 64)));
            steady = (p == 3);
            repeat (14) begin
                if ($urandom_range(0, 5) == 0)
                    queue_word(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                               6'($urandom_range(0, 63)), 1'b0);
                else
                    queue_word(gdfw_pkg::FUNC_EDGE, 6'(base + $urandom_range(0, 7)),
                               6'(base + $urandom_range(0, 7)), 1'b0);
            end
            queue_word(gdfw_pkg::FUNC_WALK, 6'(base + $urandom_range(0, 7)),
                       6'($urandom_range(0, 63)), 1'b1);
            repeat (3)
                queue_word(gdfw_pkg::FUNC_WALK, 6'(base + $urandom_range(0, 7)),
                           6'($urandom_range(0, 63)), 1'b0);
            queue_word(gdfw_pkg::FUNC_WALK, 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)), 1'b0);
        end
        steady = 1'b0;

        // Fill the edge store past capacity with edges between any vertices.
        set_vertex_count(7'd64);
        walks = 0;
        while (planned_edges < gdfw_pkg::MAX_EDGES_DEF + 6) begin
            queue_word(gdfw_pkg::FUNC_EDGE, 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)), 1'b0);
            if ($urandom_range(0, 11) == 0) begin
                queue_word(gdfw_pkg::FUNC_WALK, 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), walks == 3);
                walks++;
            end
        end

        // With a full store the range test still takes precedence.
        set_vertex_count(7'd20);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd30, 6'd1, 1'b0);
        queue_word(gdfw_pkg::FUNC_EDGE, 6'd1, 6'd2, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd1, 6'd0, 1'b0);
        queue_word(gdfw_pkg::FUNC_WALK, 6'd25, 6'd0, 1'b0);

        wait_drained();
        repeat (24) @(posedge clk);
        $display("Covered %0d input words over %0d vertex-count settings: %0d edges stored,",
                 words_taken, settings_used, edges_held);
        $display("%0d refused as full, %0d out of range; %0d walks produced %0d checked %s %0d.",
                 edges_refused_full, range_refusals, walks_run, visits_checked,
                 "visits, the longest walk reaching", longest_walk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

[graph_depth_first_walk.f]
src/gdfw_pkg.sv
src/gdfw_ram.sv
src/graph_depth_first_walk.sv
tb/sv/tb.sv
